// ===== rtl/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared widths, defaults, event codes and types for the button debouncer
// with click counting and hold-repeat.
// ----------------------------------------------------------------------------
package bdc_pkg;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 10;
  localparam int DEBOUNCE_W = 15;
  localparam int MS_W       = 16;
  localparam int CNT_W      = 16;
  localparam int DCNT_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // History length default
  localparam int HISTORY_BITS_DEF = 32;

  // Register reset values
  localparam logic [PERIOD_W-1:0]   DEF_PERIOD    = 10'd10;
  localparam logic [DEBOUNCE_W-1:0] DEF_DEBOUNCE  = 15'd20;
  localparam logic [MS_W-1:0]       DEF_REP_DELAY = 16'd300;
  localparam logic [MS_W-1:0]       DEF_REP_RATE  = 16'd200;
  localparam logic [MS_W-1:0]       DEF_WINDOW    = 16'd500;
  localparam logic [MS_W-1:0]       DEF_TIMEOUT   = 16'd1000;

  // Debounce sample count ceiling
  localparam logic [DCNT_W-1:0] MAX_DEB_COUNT = 5'd30;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REP_DELAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REP_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 3'd6;

  // Status codes
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_DISABLED = 1'b1;

  // Button events
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_REPEAT   = 2'd3
  } bdc_event_e;

  // History judgement handed from the history unit to the sequencer
  typedef struct packed {
    logic down;  // low D samples all high
    logic up;    // low D samples all low
    logic rel;   // release pattern: window is zero or bit D alone
  } bdc_judge_t;

endpackage

// ===== rtl/bdc_intf.sv =====
// ----------------------------------------------------------------------------
// bdc_intf
// Valid/ready channels of the button debouncer: sample input, result output
// and register write port.
// ----------------------------------------------------------------------------
interface bdc_in_if import bdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_value;
  logic              time_is_delta;
  logic              pin_level;

  modport source (output valid, time_value, time_is_delta, pin_level, input ready);
  modport sink   (input valid, time_value, time_is_delta, pin_level, output ready);
endinterface

interface bdc_out_if import bdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       event_res;
  logic             status;
  logic [1:0]       last_event;
  logic [CNT_W-1:0] click_count;
  logic [CNT_W-1:0] repeat_count;
  logic             busy_res;

  modport source (output valid, event_res, status, last_event, click_count,
                  repeat_count, busy_res, input ready);
  modport sink   (input valid, event_res, status, last_event, click_count,
                  repeat_count, busy_res, output ready);
endinterface

interface bdc_cfg_if import bdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bdc_div.sv =====
// ----------------------------------------------------------------------------
// bdc_div
// Restoring serial divider: 32-bit dividend by a 10-bit nonzero divisor,
// one quotient bit per cycle. done_o pulses when quotient and remainder hold.
// ----------------------------------------------------------------------------
module bdc_div import bdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [TIME_W-1:0]   dividend_i,
  input  logic [PERIOD_W-1:0] divisor_i,
  output logic                done_o,
  output logic [TIME_W-1:0]   quot_o,
  output logic [PERIOD_W-1:0] rem_o
);

  localparam int CW = $clog2(TIME_W);
  localparam logic [CW-1:0] LAST_STEP = CW'(TIME_W - 1);

  logic                busy_q, done_q;
  logic [CW-1:0]       cnt_q;
  logic [TIME_W-1:0]   quo_q;
  logic [PERIOD_W-1:0] rem_q;

  logic [PERIOD_W:0]   rem_sh, rem_sub;
  logic                ge;

  // One trial subtract per step
  always_comb begin
    rem_sh  = {rem_q, quo_q[TIME_W-1]};
    ge      = rem_sh >= {1'b0, divisor_i};
    rem_sub = ge ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in over the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[TIME_W-2:0], ge};
      rem_q <= rem_sub[PERIOD_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/bdc_hist.sv =====
// ----------------------------------------------------------------------------
// bdc_hist
// Pin level history register with multi-period shift and the debounce
// judgement (down, up, release pattern) for a sample count D.
// ----------------------------------------------------------------------------
module bdc_hist import bdc_pkg::*; #(
  parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_en_i,
  input  logic [TIME_W-1:0] pulses_i,
  input  logic              level_i,
  input  logic [DCNT_W-1:0] deb_cnt_i,
  output bdc_judge_t        judge_o
);

  localparam int SW = $clog2(HISTORY_BITS);

  logic [HISTORY_BITS-1:0] hist_q, hist_d;
  logic [HISTORY_BITS-1:0] ones, m_lo, m_win, h_bit, w_bits, lo_bits;
  logic                    fill;
  logic [SW-1:0]           sh;

  // Shift in one level per elapsed period; a long run fills the register
  always_comb begin
    ones   = '1;
    fill   = pulses_i >= TIME_W'(HISTORY_BITS);
    sh     = pulses_i[SW-1:0];
    hist_d = hist_q;
    if (shift_en_i) begin
      if (fill) begin
        hist_d = level_i ? ones : '0;
      end else begin
        hist_d = (hist_q << sh) | (level_i ? ~(ones << sh) : '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  // Masks for the low D bits, the low D+1 bits and bit D
  always_comb begin
    for (int i = 0; i < HISTORY_BITS; i++) begin
      m_lo[i]  = i < int'(deb_cnt_i);
      m_win[i] = i <= int'(deb_cnt_i);
      h_bit[i] = i == int'(deb_cnt_i);
    end
    w_bits       = hist_q & m_win;
    lo_bits      = hist_q & m_lo;
    judge_o.down = (lo_bits == m_lo) && (int'(deb_cnt_i) <= HISTORY_BITS);
    judge_o.up   = lo_bits == '0;
    judge_o.rel  = (w_bits == h_bit) || (w_bits == '0);
  end

endmodule

// ===== rtl/button_debounce_click_repeat.sv =====
// ----------------------------------------------------------------------------
// button_debounce_click_repeat
// Button debouncer with press/release detection, click counting and
// hold-repeat, driven by timestamped pin samples.
// ----------------------------------------------------------------------------
// Per sample the 32-step serial divider splits the elapsed time into whole
//   periods, the history shifts and, if a period elapsed, evaluation runs;
//   disabled: reported directly. After a period or debounce write the
// first sample also divides the debounce time. Input is taken only while
//   idle, also while a finished result waits on the output register.
// Reset: all state and registers to defaults at once, no clearing pass.
module button_debounce_click_repeat import bdc_pkg::*; #(
  parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdc_in_if.sink     in_i,
  bdc_out_if.source  out_o,
  bdc_cfg_if.sink    cfg_i
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIVD   = 3'd1;
  localparam logic [2:0] S_DIVE   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  // Configuration registers
  logic [PERIOD_W-1:0]   period_q;
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [MS_W-1:0]       rep_delay_q, rep_rate_q, window_q, timeout_q;
  logic                  enabled_q;

  // Button state
  logic [TIME_W-1:0] last_ts_q, press_time_q, release_time_q, repeat_time_q;
  logic              rep_started_q, pressed_q;
  logic [CNT_W-1:0]  clicks_q, repeats_q;
  bdc_event_e        recent_q;

  // Per-sample working registers
  logic [2:0]        state_q, state_d;
  logic              go_q, upd_q, status_q, lvl_q;
  bdc_event_e        ev_q;
  logic [TIME_W-1:0] t_q, el_q, tc_q;
  logic [DCNT_W-1:0] d_q;
  logic              d_valid_q;

  // Output register
  logic              out_valid_q;
  logic [1:0]        out_ev_q, out_last_q;
  logic              out_status_q, out_busy_q;
  logic [CNT_W-1:0]  out_clicks_q, out_repeats_q;

  // Internal nets
  logic                  cfg_we, in_acc, out_go;
  logic [PERIOD_W-1:0]   per_eff;
  logic [MS_W-1:0]       timeout_eff;
  logic [TIME_W-1:0]     t_in, div_dividend, div_quot, pulses, tc_next;
  logic [PERIOD_W-1:0]   div_rem;
  logic                  div_done, hist_shift;
  logic [DCNT_W-1:0]     d_next;
  bdc_judge_t            judge;
  logic [TIME_W-1:0]     hold_base, hold_diff, win_diff;
  logic [MS_W-1:0]       hold_thr;
  logic                  hold_fire, win_ge, closed_now, busy_now;
  logic [CNT_W-1:0]      clicks_rep;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign in_i.ready  = state_q == S_IDLE;
  assign in_acc      = in_i.valid && (state_q == S_IDLE);
  assign out_go      = (state_q == S_REPORT) && (!out_valid_q || out_o.ready);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= DEF_PERIOD;
      debounce_q  <= DEF_DEBOUNCE;
      rep_delay_q <= DEF_REP_DELAY;
      rep_rate_q  <= DEF_REP_RATE;
      window_q    <= DEF_WINDOW;
      timeout_q   <= DEF_TIMEOUT;
      enabled_q   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        REG_PERIOD:    period_q    <= cfg_i.data[PERIOD_W-1:0];
        REG_DEBOUNCE:  debounce_q  <= cfg_i.data[DEBOUNCE_W-1:0];
        REG_REP_DELAY: rep_delay_q <= cfg_i.data;
        REG_REP_RATE:  rep_rate_q  <= cfg_i.data;
        REG_WINDOW:    window_q    <= cfg_i.data;
        REG_TIMEOUT:   timeout_q   <= cfg_i.data;
        REG_ENABLED:   enabled_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Zero period reads as 1 ms, zero timeout as the default
  assign per_eff     = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign timeout_eff = (timeout_q == '0) ? DEF_TIMEOUT : timeout_q;

  // Shared divider: debounce count first when stale, then elapsed time
  assign div_dividend = (state_q == S_DIVD) ? TIME_W'(debounce_q) : el_q;

  bdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (div_dividend),
    .divisor_i  (per_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign d_next = (div_quot >= TIME_W'(MAX_DEB_COUNT)) ? MAX_DEB_COUNT
                                                      : div_quot[DCNT_W-1:0] + 1'b1;

  // Cached sample count, dropped when period or debounce changes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      d_q       <= '0;
    end else if (cfg_we && (cfg_i.index == REG_PERIOD || cfg_i.index == REG_DEBOUNCE)) begin
      d_valid_q <= 1'b0;
    end else if (state_q == S_DIVD && div_done) begin
      d_valid_q <= 1'b1;
      d_q       <= d_next;
    end
  end

  // History: a gap past the timeout counts as one period
  assign pulses     = (el_q > TIME_W'(timeout_eff)) ? TIME_W'(1) : div_quot;
  assign hist_shift = (state_q == S_SHIFT) && (div_quot != '0);
  assign tc_next    = t_q - TIME_W'(div_rem);

  bdc_hist #(
    .HISTORY_BITS (HISTORY_BITS)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (hist_shift),
    .pulses_i   (pulses),
    .level_i    (lvl_q),
    .deb_cnt_i  (d_q),
    .judge_o    (judge)
  );

  // Time of the sample
  assign t_in = in_i.time_is_delta ? (last_ts_q + in_i.time_value) : in_i.time_value;

  // Hold-repeat compare
  always_comb begin
    hold_base = rep_started_q ? repeat_time_q : press_time_q;
    hold_thr  = rep_started_q ? rep_rate_q : rep_delay_q;
    hold_diff = tc_q - hold_base;
    hold_fire = (rep_delay_q != '0) && !(rep_started_q && rep_rate_q == '0) &&
                (hold_diff >= TIME_W'(hold_thr));
  end

  // Click window at the stored timestamp
  always_comb begin
    win_diff   = last_ts_q - release_time_q;
    win_ge     = win_diff >= TIME_W'(window_q);
    closed_now = (window_q == '0) || (clicks_q == '0) || win_ge;
    clicks_rep = (upd_q && judge.up && closed_now) ? '0 : clicks_q;
    busy_now   = !judge.up || !((window_q == '0) || (clicks_rep == '0) || win_ge);
  end

  // Next sequencer state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!enabled_q)     state_d = S_REPORT;
          else if (d_valid_q) state_d = S_DIVE;
          else                state_d = S_DIVD;
        end
      end
      S_DIVD:   if (div_done) state_d = S_DIVE;
      S_DIVE:   if (div_done) state_d = S_SHIFT;
      S_SHIFT:  state_d = (div_quot == '0) ? S_REPORT : S_EVAL;
      S_EVAL:   state_d = S_REPORT;
      S_REPORT: if (out_go) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer and button state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      go_q           <= 1'b0;
      upd_q          <= 1'b0;
      status_q       <= ST_OK;
      ev_q           <= EV_NONE;
      last_ts_q      <= '0;
      press_time_q   <= '0;
      release_time_q <= '0;
      repeat_time_q  <= '0;
      rep_started_q  <= 1'b0;
      pressed_q      <= 1'b0;
      clicks_q       <= '0;
      repeats_q      <= '0;
      recent_q       <= EV_NONE;
    end else begin
      state_q <= state_d;
      go_q    <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            upd_q    <= 1'b0;
            ev_q     <= EV_NONE;
            status_q <= enabled_q ? ST_OK : ST_DISABLED;
            go_q     <= enabled_q;
          end
        end
        S_DIVD: begin
          if (div_done) go_q <= 1'b1;
        end
        S_EVAL: begin
          upd_q     <= 1'b1;
          last_ts_q <= tc_q;
          if (!pressed_q && judge.down) begin
            ev_q          <= EV_PRESSED;
            recent_q      <= EV_PRESSED;
            press_time_q  <= tc_q;
            repeat_time_q <= '0;
            rep_started_q <= 1'b0;
            repeats_q     <= '0;
            clicks_q      <= clicks_q + 1'b1;
            pressed_q     <= 1'b1;
          end else if (pressed_q && judge.rel) begin
            ev_q           <= EV_RELEASED;
            recent_q       <= EV_RELEASED;
            release_time_q <= tc_q;
            pressed_q      <= 1'b0;
          end else if (judge.down && hold_fire) begin
            ev_q          <= EV_REPEAT;
            recent_q      <= EV_REPEAT;
            repeat_time_q <= tc_q;
            rep_started_q <= 1'b1;
            repeats_q     <= repeats_q + 1'b1;
          end
        end
        S_REPORT: begin
          if (out_go) clicks_q <= clicks_rep;
        end
        default: ;
      endcase
    end
  end

  // Sample payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q   <= t_in;
      el_q  <= t_in - last_ts_q;
      lvl_q <= in_i.pin_level;
    end
    if (state_q == S_SHIFT) tc_q <= tc_next;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_go) begin
      out_ev_q      <= ev_q;
      out_status_q  <= status_q;
      out_last_q    <= recent_q;
      out_clicks_q  <= clicks_rep;
      out_repeats_q <= repeats_q;
      out_busy_q    <= busy_now;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_res    = out_ev_q;
  assign out_o.status       = out_status_q;
  assign out_o.last_event   = out_last_q;
  assign out_o.click_count  = out_clicks_q;
  assign out_o.repeat_count = out_repeats_q;
  assign out_o.busy_res     = out_busy_q;

`ifndef NO_ASSERTIONS
  // Divider only finishes while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVD || state_q == S_DIVE))
    else $error("divider finished outside a divide state");

  // Click count moves only on evaluation or report
  a_clicks_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clicks_q != $past(clicks_q)) |->
      ($past(state_q) == S_EVAL || $past(state_q) == S_REPORT))
    else $error("click count changed outside evaluation or report");

  // Repeat count moves only with a press or a repeat event
  a_repeats_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (repeats_q != $past(repeats_q)) |-> (ev_q == EV_PRESSED || ev_q == EV_REPEAT))
    else $error("repeat count changed without press or repeat");

  // Pressed state is entered only with a press event
  a_press_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pressed_q) |-> (ev_q == EV_PRESSED))
    else $error("pressed without press event");
`endif

endmodule
